/* rtl/gbm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// GBM log-Euler package
// Shared payload types, register indexes and fixed-point constants of the
// log-Euler path stepper.
// ----------------------------------------------------------------------------
package gbm_pkg;

	// Input item: Brownian increment (Q4.12) and path start flag
	typedef struct packed {
		logic signed [15:0] increment;
		logic               path_start;
	} in_item_t;

	// Result item: price (Q16.16), log price (Q8.24), saturation flag
	typedef struct packed {
		logic [31:0]        price;
		logic signed [31:0] log_price;
		logic               overflowed;
	} out_item_t;

	// Configuration register file
	typedef struct packed {
		logic signed [31:0] drift_per_step;
		logic [15:0]        volatility;
		logic signed [31:0] log_start_price;
	} cfg_regs_t;

	// Register indexes
	localparam logic [1:0] CFG_DRIFT      = 2'd0;
	localparam logic [1:0] CFG_VOLATILITY = 2'd1;
	localparam logic [1:0] CFG_LOG_START  = 2'd2;

	// log2(e) in Q2.30
	localparam logic [31:0] LOG2E_Q30 = 32'd1549082005;
	// 1.0 in Q1.30
	localparam logic [30:0] ONE_Q30 = 31'd1073741824;
	// Highest-order Taylor coefficient of 2^f, seeds the Horner chain
	localparam logic [30:0] EXP2_SEED = 31'd109;
	// Index of the final Horner pass, which adds 1.0
	localparam logic [3:0] POLY_LAST = 4'd8;

	// Coefficient added on Horner pass idx: descending powers, then 1.0
	function automatic logic [30:0] horner_coef(input logic [3:0] idx);
		logic [30:0] c;
		unique case (idx)
			4'd0:    c = 31'd1419;
			4'd1:    c = 31'd16377;
			4'd2:    c = 31'd165394;
			4'd3:    c = 31'd1431680;
			4'd4:    c = 31'd10327387;
			4'd5:    c = 31'd59597083;
			4'd6:    c = 31'd257941248;
			4'd7:    c = 31'd744261118;
			default: c = ONE_Q30;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

/* rtl/gbm_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// GBM front end
// Takes input items, reloads or advances the log-price accumulator and
// pushes the new log price toward the exponential back end.
// ----------------------------------------------------------------------------
module gbm_front import gbm_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cfg_regs_t          cfg,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire in_item_t           in_data,
	input  wire logic               q_full,
	output logic                    q_push,
	output logic signed [31:0]      q_wdata
);

	logic signed [31:0] acc_q;
	logic signed [31:0] acc_base;
	logic signed [32:0] diffusion;
	logic               accept;

	// Hold off new items while the queue has no room
	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	// Volatility times increment is exact in Q8.24
	assign diffusion = $signed({1'b0, cfg.volatility}) * in_data.increment;
	assign acc_base  = in_data.path_start ? cfg.log_start_price : acc_q;
	assign q_wdata   = acc_base + cfg.drift_per_step + diffusion[31:0];
	assign q_push    = accept;

	// Advance the accumulator on every transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (accept) begin
			acc_q <= q_wdata;
		end
	end

endmodule
`default_nettype wire

/* rtl/gbm_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// GBM log-price queue
// Small FIFO of log prices between the accumulator and the exp sequencer.
// ----------------------------------------------------------------------------
module gbm_queue import gbm_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire logic signed [31:0] wdata,
	output logic                    full,
	input  wire logic               pop,
	output logic signed [31:0]      rdata,
	output logic                    empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	logic signed [31:0] mem_q [DEPTH];
	logic [PW-1:0]      wr_ptr_q;
	logic [PW-1:0]      rd_ptr_q;
	logic [CW-1:0]      count_q;

	assign full  = (count_q == CNT_FULL);
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and track fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("queue written while full");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("queue read while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("queue fill level out of range");

endmodule
`default_nettype wire

/* rtl/gbm_exp_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// GBM exponential back end
// Turns one log price at a time into a saturating Q16.16 price: scale by
// log2(e), evaluate 2^frac with a shared multiplier over nine Horner passes,
// then shift by the integer part with rounding.
// ----------------------------------------------------------------------------
module gbm_exp_back import gbm_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_empty,
	input  wire logic signed [31:0] q_rdata,
	output logic                    q_pop,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output out_item_t               out_data
);

	typedef enum logic [1:0] {ST_IDLE, ST_LOG2, ST_POLY, ST_SCALE} state_t;

	state_t             state_q;
	logic signed [31:0] x_q;
	logic signed [32:0] y_q;
	logic [30:0]        acc_q;
	logic [3:0]         step_q;
	logic               out_valid_q;
	out_item_t          out_data_q;

	logic signed [63:0] log2_prod;
	logic [29:0]        u;
	logic [60:0]        poly_prod;
	logic [31:0]        poly_sum;
	logic signed [9:0]  sh;
	logic [4:0]         rsh;
	logic [32:0]        left_val;
	logic [31:0]        rounded;
	logic [31:0]        price;
	logic               ovf;
	logic               out_free;
	logic               res_load;

	assign q_pop    = (state_q == ST_IDLE) && !q_empty;
	assign out_free = !out_valid_q || !out_stall;
	assign res_load = (state_q == ST_SCALE) && out_free;

	// Scale log price by log2(e): y = floor(x * log2e / 2^30) in Q.24
	assign log2_prod = x_q * $signed({1'b0, LOG2E_Q30});

	// One Horner pass on the fraction in Q0.30
	assign u         = {y_q[23:0], 6'b0};
	assign poly_prod = acc_q * u;
	assign poly_sum  = {1'b0, horner_coef(step_q)} + {1'b0, poly_prod[60:30]};

	// Shift mantissa by k - 14, saturate above, round half up below
	assign sh       = $signed({y_q[32], y_q[32:24]}) - 10'sd14;
	assign rsh      = 5'(-sh);
	assign left_val = {2'b0, acc_q} << sh[0];
	assign rounded  = ({1'b0, acc_q} + (32'd1 << (rsh - 5'd1))) >> rsh;

	always_comb begin
		price = '0;
		ovf   = 1'b0;
		priority if (sh >= 10'sd2) begin
			price = '1;
			ovf   = 1'b1;
		end else if (sh >= 10'sd0) begin
			if (left_val[32]) begin
				price = '1;
				ovf   = 1'b1;
			end else begin
				price = left_val[31:0];
			end
		end else if (sh <= -10'sd31) begin
			price = '0;
		end else begin
			price = rounded;
		end
	end

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			step_q      <= '0;
			x_q         <= '0;
			y_q         <= '0;
			acc_q       <= '0;
			out_data_q  <= '0;
		end else begin
			// Raise the result on a load, drop it once transferred
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						x_q     <= q_rdata;
						state_q <= ST_LOG2;
					end
				end
				ST_LOG2: begin
					y_q     <= log2_prod[62:30];
					acc_q   <= EXP2_SEED;
					step_q  <= '0;
					state_q <= ST_POLY;
				end
				ST_POLY: begin
					acc_q <= poly_sum[30:0];
					if (step_q == POLY_LAST) begin
						state_q <= ST_SCALE;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_SCALE: begin
					if (out_free) begin
						out_data_q.price      <= price;
						out_data_q.log_price  <= x_q;
						out_data_q.overflowed <= ovf;
						state_q               <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_poly_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POLY) |-> (step_q <= POLY_LAST))
		else $error("Horner pass count out of range");
	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (state_q == ST_LOG2))
		else $error("pop did not start an exp sequence");
	a_result_after_scale: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_SCALE))
		else $error("result raised outside the scale step");

endmodule
`default_nettype wire

/* rtl/gbm_log_euler_path_step.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// GBM log-Euler path step
// Monte Carlo price path stepper: log-price accumulator plus fixed-point exp.
// ----------------------------------------------------------------------------
// Each input transfer adds drift plus volatility times the increment to the
// log price (reloaded from the start log price when path_start is set) and
// yields one result carrying the Q8.24 log price and its Q16.16 exponential.
// The accumulator takes one item per cycle while the queue has room and
// parks log prices in a QUEUE_DEPTH-entry queue; the exp sequencer behind it
// scales by log2(e) on its own multiplier and shares a second one across
// nine Horner passes, so it works on one log price at a time and pops no
// new one until its result is loaded. Configuration writes are always ready
// and must be made while no item is in flight.
// ----------------------------------------------------------------------------
module gbm_log_euler_path_step import gbm_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire in_item_t    in_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output out_item_t        out_data,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	cfg_regs_t          cfg_q;
	logic               q_full;
	logic               q_push;
	logic signed [31:0] q_wdata;
	logic               q_pop;
	logic signed [31:0] q_rdata;
	logic               q_empty;

	assign cfg_ready = 1'b1;

	// Register writes; unused index drops the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_DRIFT:      cfg_q.drift_per_step  <= cfg_data;
				CFG_VOLATILITY: cfg_q.volatility      <= cfg_data[15:0];
				CFG_LOG_START:  cfg_q.log_start_price <= cfg_data;
				default: ;
			endcase
		end
	end

	gbm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_wdata  (q_wdata)
	);

	gbm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	gbm_exp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_rdata   (q_rdata),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

/* tb/gbm_step_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GBM path step checker
// Watches the register, step and price channels of the log-Euler stepper.
// It keeps its own copy of the registers and the log-price accumulator,
// predicts the price record for each step, and compares every price transfer
// with the oldest prediction.
// ----------------------------------------------------------------------------
module gbm_step_checker import gbm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  in_item_t    in_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  out_item_t   out_data,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int unsigned fail_count,
	output int unsigned pending
);

	// Taylor terms of 2^f in Q1.30, degree 1 at index 0 up to degree 8
	localparam logic [7:0][31:0] TAYLOR = {
		32'd1419, 32'd16377, 32'd165394, 32'd1431680,
		32'd10327387, 32'd59597083, 32'd257941248, 32'd744261118
	};
	// Degree 9 term, start of the Horner chain
	localparam logic [63:0] TAYLOR_TOP = 64'd109;

	logic signed [31:0] drift_q24;
	logic [15:0]        sigma_q12;
	logic signed [31:0] start_log_q24;
	logic signed [31:0] log_acc_q24;
	out_item_t          price_q[$];
	int unsigned        result_num;

	// Exponential of a Q8.24 log value as a saturating Q16.16 price;
	// bit 32 flags saturation
	function automatic logic [32:0] log_to_price(input logic signed [31:0] lg);
		longint      scaled;
		logic [63:0] biased;
		longint      whole;
		logic [63:0] frac_q30;
		logic [63:0] horner;
		logic [63:0] mant;
		logic [63:0] shifted;
		int          shamt;
		int          i;
		// scale by log2(e); the bias keeps the floor an unsigned shift
		scaled = longint'(lg) * longint'(LOG2E_Q30);
		biased = (unsigned'(scaled) + 64'h4000_0000_0000_0000) >> 30;
		whole = longint'(biased >> 24) - 256;
		frac_q30 = 64'(biased[23:0]) << 6;
		// 2^frac by Horner, each product truncated to Q1.30
		horner = TAYLOR_TOP;
		for (i = 7; i >= 0; i--)
			horner = 64'(TAYLOR[i]) + ((horner * frac_q30) >> 30);
		mant = (64'd1 << 30) + ((horner * frac_q30) >> 30);
		// place the binary point: Q1.30 to Q16.16 is a shift by 14
		shamt = int'(whole - 14);
		if (shamt >= 2)
			return {1'b1, 32'hFFFF_FFFF};
		if (shamt >= 0) begin
			shifted = mant << shamt;
			if (shifted > 64'h0000_0000_FFFF_FFFF)
				return {1'b1, 32'hFFFF_FFFF};
			return {1'b0, shifted[31:0]};
		end
		if (-shamt >= 31)
			return {1'b0, 32'd0};
		shifted = (mant + (64'd1 << (-shamt - 1))) >> (-shamt);
		return {1'b0, shifted[31:0]};
	endfunction

	// Track registers and accumulator, predict each step, compare each price
	always @(posedge clk or negedge arst_n) begin : track
		logic [31:0] shock;
		logic [31:0] next_log;
		logic [32:0] px;
		out_item_t   want;
		if (!arst_n) begin
			drift_q24     <= '0;
			sigma_q12     <= '0;
			start_log_q24 <= '0;
			log_acc_q24   <= '0;
			fail_count    <= 0;
			pending       <= 0;
			result_num    <= 0;
			price_q.delete();
		end else begin
			// register write transfer
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_DRIFT:      drift_q24 <= cfg_data;
					CFG_VOLATILITY: sigma_q12 <= cfg_data[15:0];
					CFG_LOG_START:  start_log_q24 <= cfg_data;
					default:        ;
				endcase
			end
			// step transfer: reload on path start, add drift and shock
			if (in_valid && !in_stall) begin
				shock = 32'(longint'(sigma_q12) * longint'(in_data.increment));
				next_log = (in_data.path_start ? start_log_q24 : log_acc_q24)
					+ drift_q24 + shock;
				px = log_to_price(next_log);
				want.price = px[31:0];
				want.log_price = next_log;
				want.overflowed = px[32];
				price_q.push_back(want);
				log_acc_q24 <= next_log;
			end
			// price transfer against the oldest prediction
			if (out_valid && !out_stall) begin
				result_num <= result_num + 1;
				if (price_q.size() == 0) begin
					if (fail_count < 10)
						$display("result %0d: unexpected price %h log_price %h overflowed %b",
							result_num, out_data.price, out_data.log_price,
							out_data.overflowed);
					fail_count <= fail_count + 1;
				end else begin
					want = price_q.pop_front();
					if (out_data.price !== want.price
							|| out_data.log_price !== want.log_price
							|| out_data.overflowed !== want.overflowed) begin
						if (fail_count < 10)
							$display("result %0d: price %h/%h log_price %h/%h overflowed %b/%b (exp/got)",
								result_num, want.price, out_data.price,
								want.log_price, out_data.log_price,
								want.overflowed, out_data.overflowed);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= price_q.size();
		end
	end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GBM path step testbench
// Drives register settings and Brownian increments into the log-Euler path
// stepper with random gaps and output stalls: a directed pass over extremes,
// saturation, underflow and accumulator wrap, then random price paths under
// random settings. The checker beside the block predicts every price.
// ----------------------------------------------------------------------------
module tb_top;
	import gbm_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_stall;
	out_item_t   out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	int unsigned fails;
	int unsigned pending;
	logic        calm;

	gbm_log_euler_path_step dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	gbm_step_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fails),
		.pending    (pending)
	);

	// 8 ns clock
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Run limit, far above the slowest correct run
	initial begin
		#5_000_000;
		$display("tb_top: errors");
		$finish;
	end

	// Idle length: mostly none or short, now and then long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// Increment: full range, extremes, or a moderate uniform draw
	function automatic logic signed [15:0] pick_increment();
		logic [31:0] r;
		r = $urandom();
		case ($urandom_range(0, 3))
			0: return r[15:0];
			1: begin
				case (r[1:0])
					2'd0:    return 16'sh7FFF;
					2'd1:    return 16'sh8000;
					2'd2:    return 16'sh0000;
					default: return 16'shFFFF;
				endcase
			end
			default: return 16'($urandom_range(0, 8192)) - 16'sd4096;
		endcase
	endfunction

	// Price stall: random gaps, with stall-free stretches now and then
	initial begin
		int n;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 24) == 0) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(20, 80)) @(posedge clk);
			end
			n = gap_len();
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
		end
	end

	// One step transfer, after an optional idle gap
	task automatic push_step(input logic signed [15:0] inc, input logic start);
		int n;
		n = calm ? 0 : gap_len();
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data.increment <= inc;
		in_data.path_start <= start;
		do @(posedge clk); while (in_stall);
	endtask

	// One register transfer; valid stays up for the caller to drop
	task automatic put_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_regs(input logic [31:0] drift, input logic [15:0] sigma,
			input logic [31:0] start_log);
		put_reg(CFG_DRIFT, drift);
		put_reg(CFG_VOLATILITY, {16'd0, sigma});
		put_reg(CFG_LOG_START, start_log);
		cfg_valid <= 1'b0;
	endtask

	// Hold off until every predicted price has arrived, then let the pipe drain
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		int phase;
		int sent;
		int path_len;
		int j;
		logic        broken;
		logic [31:0] drift;
		logic [15:0] sigma;
		logic [31:0] start_log;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_DRIFT;
		cfg_data = '0;
		calm = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: steps before any path start stay at log zero
		push_step(16'sh7FFF, 1'b0);
		push_step(16'sh8000, 1'b1);
		settle();

		// full volatility against extreme increments
		load_regs(32'd0, 16'hFFFF, 32'd0);
		push_step(16'sh7FFF, 1'b1);
		push_step(16'sh7FFF, 1'b0);
		push_step(16'sh8000, 1'b0);
		push_step(16'sh8000, 1'b0);
		push_step(16'shFFFF, 1'b0);
		push_step(16'sh0000, 1'b1);
		settle();

		// highest log start: price saturates
		load_regs(32'd0, 16'd0, 32'h7FFF_FFFF);
		push_step(16'sh0000, 1'b1);
		push_step(16'sh7FFF, 1'b0);
		settle();

		// drift and start at opposite extremes, accumulator wraps
		load_regs(32'h7FFF_FFFF, 16'hFFFF, 32'h8000_0000);
		push_step(16'sh0000, 1'b1);
		push_step(16'sh8000, 1'b0);
		push_step(16'sh7FFF, 1'b0);
		push_step(16'sh0000, 1'b1);
		settle();

		// most negative drift and start: wrap to zero, then underflow
		load_regs(32'h8000_0000, 16'h8000, 32'h8000_0000);
		push_step(16'sh0000, 1'b1);
		push_step(16'sh0000, 1'b0);
		push_step(16'sh8000, 1'b0);
		settle();

		// walk across the saturation threshold one LSB at a time
		load_regs(32'd1, 16'd1, 32'd186065277);
		push_step(16'sh0000, 1'b1);
		push_step(16'sh0000, 1'b0);
		push_step(16'sh0000, 1'b0);
		push_step(16'sh0000, 1'b0);
		settle();

		// walk across the underflow threshold
		load_regs(32'd1, 16'd1, 32'hF4E8_D77E);
		push_step(16'sh0000, 1'b1);
		push_step(16'sh0000, 1'b0);
		push_step(16'sh0000, 1'b0);
		push_step(16'sh0000, 1'b0);
		settle();

		// random settings, each followed by a batch of price paths
		for (phase = 0; phase < 8; phase++) begin
			case ($urandom_range(0, 4))
				0:       drift = 32'd0;
				1:       drift = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
				2:       drift = $urandom();
				default: drift = $urandom_range(0, 65535) - 32'd32768;
			endcase
			case ($urandom_range(0, 4))
				0:       sigma = 16'd0;
				1:       sigma = 16'hFFFF;
				2:       sigma = 16'($urandom());
				default: sigma = 16'($urandom_range(200, 2000));
			endcase
			case ($urandom_range(0, 4))
				0:       start_log = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
				1:       start_log = $urandom();
				default: start_log = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
			endcase
			load_regs(drift, sigma, start_log);
			calm = ($urandom_range(0, 3) == 0);
			sent = 0;
			while (sent < 50) begin
				// mostly clean paths; some with stray path starts
				path_len = $urandom_range(1, 12);
				broken = ($urandom_range(0, 7) == 0);
				for (j = 0; j < path_len && sent < 50; j++) begin
					push_step(pick_increment(),
						broken ? 1'($urandom_range(0, 1)) : (j == 0));
					sent++;
				end
			end
			calm = 1'b0;
			settle();
		end

		if (fails == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
